/* src/speed_to_step_pulse_generator_unit_macros.svh */
// ----------------------------------------------------------------------------
// Speed-to-step pulse generator assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SPEED_TO_STEP_PULSE_GENERATOR_UNIT_MACROS_SVH
`define SPEED_TO_STEP_PULSE_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define STSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/stsp_pkg.sv */
// ----------------------------------------------------------------------------
// Speed-to-step pulse generator package
// Field widths, operation and mode codes, and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package stsp_pkg;

    localparam int OP_W        = 2;
    localparam int SPEED_W     = 24;
    localparam int RATE_W      = 28;
    localparam int RATE_MAG_W  = 27;
    localparam int PERIOD_W    = 30;
    localparam int COUNT_W     = 31;
    localparam int PPR_W       = 21;
    localparam int RAMP_W      = 10;
    localparam int MODE_W      = 2;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 21;
    localparam int FRAC_W      = 8;
    localparam int DIV_NUM_W   = 46;

    localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
    localparam logic [OP_W-1:0] OP_SPEED   = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    localparam logic [MODE_W-1:0] MODE_STEP_DIR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PARITY   = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_STEPS_PER_REV = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PULSE_MODE    = 1'd1;

    localparam logic [PPR_W-1:0]    STEPS_PER_REV_RESET = 21'd3200;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX          = {PERIOD_W{1'b1}};
    localparam logic [COUNT_W-1:0]  COUNT_MAX           = {COUNT_W{1'b1}};

    localparam int DEG_PER_REV     = 360;
    localparam int CREEP_DIVISOR   = 120;
    localparam int ZERO_RATE_SCALE = 1000;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [SPEED_W-1:0] speed_dps;
        logic                      limit_fwd;
        logic                      limit_rev;
    } item_t;

    typedef struct packed {
        logic                     line_a;
        logic                     line_b;
        logic signed [RATE_W-1:0] rate_pulses;
        logic [PERIOD_W-1:0]      period_ticks;
    } result_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } div_status_t;

    typedef struct packed {
        logic               start;
        logic               restart;
        logic [SPEED_W-1:0] speed;
        logic               limit_fwd;
        logic               limit_rev;
    } cmd_req_t;

    typedef struct packed {
        logic                busy;
        logic                done;
        logic [RATE_W-1:0]   rate;
        logic [PERIOD_W-1:0] period;
    } cmd_result_t;

endpackage

`default_nettype wire

/* src/stsp_ifs.sv */
// ----------------------------------------------------------------------------
// Speed-to-step pulse generator channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface stsp_item_if;
    logic           valid;
    logic           ready;
    stsp_pkg::item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stsp_result_if;
    logic              valid;
    logic              ready;
    stsp_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* src/stsp_divider.sv */
// ----------------------------------------------------------------------------
// Speed-to-step iterative divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stsp_divider #(
    parameter int DEN_W = 41
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [stsp_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [DEN_W-1:0]               den,
    output stsp_pkg::div_status_t               status
);

    localparam int NUM_W = stsp_pkg::DIV_NUM_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0] shifted;
    logic [DEN_W:0] diff;
    logic           take;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign take    = shifted >= {1'b0, den_reg};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], take};
        end
    end

    assign status.done     = done_reg;
    assign status.quotient = quo_reg;

endmodule

`default_nettype wire

/* src/stsp_sequencer.sv */
// ----------------------------------------------------------------------------
// Speed-to-step command sequencer
// Ramp blend, rate and tick divider through one shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

module stsp_sequencer #(
    parameter int CONTROL_RATE_HZ = 1000,
    parameter int TICK_RATE_HZ    = 100000,
    parameter int RAMP_STEPS      = 100,
    parameter int MIN_PERIOD      = 3
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire stsp_pkg::cmd_req_t         req,
    input  wire logic [stsp_pkg::PPR_W-1:0] steps_per_rev,
    output stsp_pkg::cmd_result_t           res
);

    localparam int    NUM_W    = stsp_pkg::DIV_NUM_W;
    localparam int    SPEED_W  = stsp_pkg::SPEED_W;
    localparam int    MAG_W    = stsp_pkg::RATE_MAG_W;
    localparam int    PPR_W    = stsp_pkg::PPR_W;
    localparam int    RAMP_W   = stsp_pkg::RAMP_W;
    localparam int    DELTA_W  = SPEED_W + 1;
    localparam int    BLEND_W  = DELTA_W + RAMP_W;
    localparam int    PROD_W   = SPEED_W + PPR_W;
    localparam int    WIDE_W   = stsp_pkg::PERIOD_W + 1;
    localparam int    CR_W     = $clog2(CONTROL_RATE_HZ + 1);
    localparam int    DEN_W    = MAG_W + CR_W;
    localparam int    RATE_DEN  = stsp_pkg::DEG_PER_REV * CONTROL_RATE_HZ;
    localparam int    CREEP_DEN = stsp_pkg::CREEP_DIVISOR * CONTROL_RATE_HZ;
    localparam longint TICK_NUM = longint'(TICK_RATE_HZ) * 256;

    localparam logic [RAMP_W-1:0] RAMP_Q = RAMP_W'(RAMP_STEPS);
    localparam logic [CR_W-1:0]   CR_Q   = CR_W'(CONTROL_RATE_HZ);
    localparam logic [WIDE_W-1:0] MIN_Q  = WIDE_W'(MIN_PERIOD);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_BLEND_MUL  = 10'b00_0000_0010,
        S_BLEND_DIV  = 10'b00_0000_0100,
        S_BLEND_ADD  = 10'b00_0000_1000,
        S_RATE_MUL   = 10'b00_0001_0000,
        S_RATE_DIV   = 10'b00_0010_0000,
        S_RATE_CLAMP = 10'b00_0100_0000,
        S_PER_MUL    = 10'b00_1000_0000,
        S_PER_DIV    = 10'b01_0000_0000,
        S_FINISH     = 10'b10_0000_0000
    } seq_state_t;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [SPEED_W-1:0] smoothed_speed_reg;
    logic [RAMP_W-1:0]  ramp_count_reg;
    logic [DELTA_W-1:0] delta_mag_reg;
    logic               delta_neg_reg;
    logic               limit_fwd_reg;
    logic               limit_rev_reg;
    logic               rate_neg_reg;
    logic [MAG_W-1:0]   rate_mag_reg;
    logic [WIDE_W-1:0]  period_wide_reg;

    logic [DELTA_W-1:0] speed_ext;
    logic [DELTA_W-1:0] smooth_ext;
    logic [DELTA_W-1:0] delta;
    logic [RAMP_W-1:0]  ramp_factor;
    logic [BLEND_W-1:0] blend_prod;
    logic [DELTA_W-1:0] blend_q;
    logic [DELTA_W-1:0] smooth_sum;
    logic [SPEED_W-1:0] smooth_mag;
    logic [PROD_W-1:0]  rate_prod;
    logic               limit_any;
    logic [MAG_W-1:0]   rate_lim;
    logic [DEN_W-1:0]   per_den;
    logic [WIDE_W-1:0]  zero_period;
    logic [stsp_pkg::RATE_W-1:0] rate_pos;

    logic                  div_start;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    stsp_pkg::div_status_t div_status;

    stsp_divider #(
        .DEN_W (DEN_W)
    ) u_divider (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .status (div_status)
    );

    assign speed_ext   = {req.speed[SPEED_W-1], req.speed};
    assign smooth_ext  = {smoothed_speed_reg[SPEED_W-1], smoothed_speed_reg};
    assign delta       = speed_ext - smooth_ext;
    assign ramp_factor = (ramp_count_reg > RAMP_Q) ? '0 : RAMP_Q - ramp_count_reg;
    assign blend_prod  = BLEND_W'(delta_mag_reg) * BLEND_W'(ramp_factor);
    assign blend_q     = div_status.quotient[DELTA_W-1:0];
    assign smooth_sum  = delta_neg_reg ? smooth_ext - blend_q : smooth_ext + blend_q;
    assign smooth_mag  = smoothed_speed_reg[SPEED_W-1] ? (~smoothed_speed_reg + 1'b1)
                                                       : smoothed_speed_reg;
    assign rate_prod   = PROD_W'(smooth_mag) * PROD_W'(steps_per_rev);
    assign limit_any   = limit_fwd_reg || limit_rev_reg;
    assign rate_lim    = {steps_per_rev[PPR_W-1:2], {stsp_pkg::FRAC_W{1'b0}}};
    assign per_den     = DEN_W'(rate_mag_reg) * DEN_W'(CR_Q);
    assign zero_period = WIDE_W'(steps_per_rev) * WIDE_W'(stsp_pkg::ZERO_RATE_SCALE);
    assign rate_pos    = {1'b0, rate_mag_reg};

    always_comb
    begin
        div_start = 1'b0;
        div_num   = NUM_W'(TICK_NUM);
        div_den   = per_den;
        unique case (state_reg)
            S_BLEND_MUL:
            begin
                div_start = 1'b1;
                div_num   = NUM_W'(blend_prod);
                div_den   = DEN_W'(RAMP_STEPS);
            end
            S_RATE_MUL:
            begin
                div_start = 1'b1;
                if (limit_any)
                begin
                    div_num = NUM_W'({steps_per_rev, {stsp_pkg::FRAC_W{1'b0}}});
                    div_den = DEN_W'(CREEP_DEN);
                end
                else
                begin
                    div_num = NUM_W'({rate_prod, 1'b0});
                    div_den = DEN_W'(RATE_DEN);
                end
            end
            S_PER_MUL:
            begin
                div_start = (rate_mag_reg != '0);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:       if (req.start) state_next = S_BLEND_MUL;
            S_BLEND_MUL:  state_next = S_BLEND_DIV;
            S_BLEND_DIV:  if (div_status.done) state_next = S_BLEND_ADD;
            S_BLEND_ADD:  state_next = S_RATE_MUL;
            S_RATE_MUL:   state_next = S_RATE_DIV;
            S_RATE_DIV:   if (div_status.done) state_next = S_RATE_CLAMP;
            S_RATE_CLAMP: state_next = S_PER_MUL;
            S_PER_MUL:    state_next = (rate_mag_reg == '0) ? S_FINISH : S_PER_DIV;
            S_PER_DIV:    if (div_status.done) state_next = S_FINISH;
            S_FINISH:     state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            smoothed_speed_reg <= '0;
            ramp_count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (req.restart)
            begin
                ramp_count_reg <= RAMP_Q;
            end
            else if ((state_reg == S_IDLE) && req.start && (ramp_count_reg != '0))
            begin
                ramp_count_reg <= ramp_count_reg - 1'b1;
            end
            if (state_reg == S_BLEND_ADD)
            begin
                smoothed_speed_reg <= smooth_sum[SPEED_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && req.start)
        begin
            delta_neg_reg <= delta[DELTA_W-1];
            delta_mag_reg <= delta[DELTA_W-1] ? (~delta + 1'b1) : delta;
            limit_fwd_reg <= req.limit_fwd;
            limit_rev_reg <= req.limit_rev;
        end
        if (state_reg == S_RATE_MUL)
        begin
            rate_neg_reg <= limit_fwd_reg ? 1'b0
                          : (limit_rev_reg ? 1'b1 : smoothed_speed_reg[SPEED_W-1]);
        end
        if (state_reg == S_RATE_CLAMP)
        begin
            if (!limit_any && (div_status.quotient > NUM_W'(rate_lim)))
            begin
                rate_mag_reg <= rate_lim;
            end
            else
            begin
                rate_mag_reg <= div_status.quotient[MAG_W-1:0];
            end
        end
        if ((state_reg == S_PER_MUL) && (rate_mag_reg == '0))
        begin
            period_wide_reg <= zero_period;
        end
        if ((state_reg == S_PER_DIV) && div_status.done)
        begin
            period_wide_reg <= div_status.quotient[WIDE_W-1:0];
        end
    end

    assign res.busy = (state_reg != S_IDLE);
    assign res.done = (state_reg == S_FINISH);
    assign res.rate = rate_neg_reg ? (~rate_pos + 1'b1) : rate_pos;

    assign res.period = (period_wide_reg < MIN_Q) ? MIN_Q[stsp_pkg::PERIOD_W-1:0]
                      : (period_wide_reg > WIDE_W'(stsp_pkg::PERIOD_MAX))
                        ? stsp_pkg::PERIOD_MAX
                        : period_wide_reg[stsp_pkg::PERIOD_W-1:0];

endmodule

`default_nettype wire

/* src/speed_to_step_pulse_generator_unit.sv */
// ----------------------------------------------------------------------------
// Speed-to-step pulse generator unit
// One stepper axis: ramped speed to pulse rate, tick divider and step lines.
// ----------------------------------------------------------------------------
// Channel  Side  Handshake     Payload
// item     in    valid/ready   operation, speed_dps, limit_fwd, limit_rev
// result   out   valid/ready   line_a, line_b, rate_pulses, period_ticks
// config   in    wr_en         reg_index, wr_data
//
// A tick, restart or unknown request gives its result the next cycle; a new
// one is taken in the same cycle as the previous result leaves.
// A speed command gives its result after three divider passes (46 quotient
// bits plus done) and six sequencing states; a zero rate skips the last
// pass. No request is taken meanwhile.
// Reset (async, active low) clears control regs; steps_per_rev 3200, mode 1.
// A result not yet taken holds off the next request.
// ----------------------------------------------------------------------------
`default_nettype none

module speed_to_step_pulse_generator_unit #(
    parameter int CONTROL_RATE_HZ = 1000,
    parameter int TICK_RATE_HZ    = 100000,
    parameter int RAMP_STEPS      = 100,
    parameter int MIN_PERIOD      = 3
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             wr_en,
    input  wire logic [stsp_pkg::CFG_INDEX_W-1:0] reg_index,
    input  wire logic [stsp_pkg::CFG_DATA_W-1:0]  wr_data,
    stsp_item_if.sink                             item,
    stsp_result_if.source                         result
);

    localparam int RATE_W   = stsp_pkg::RATE_W;
    localparam int COUNT_W  = stsp_pkg::COUNT_W;
    localparam int FRAC_W   = stsp_pkg::FRAC_W;

    logic [stsp_pkg::PPR_W-1:0]    steps_per_rev_reg;
    logic [stsp_pkg::MODE_W-1:0]   pulse_mode_reg;
    logic [RATE_W-1:0]             pulse_rate_reg;
    logic [stsp_pkg::PERIOD_W-1:0] tick_divider_reg;
    logic [COUNT_W-1:0]            tick_counter_reg;
    logic                          step_level_reg;
    logic [1:0]                    line_state_reg;
    logic                          result_valid_reg;

    logic                  accept;
    logic                  is_tick;
    logic                  is_speed;
    logic                  is_restart;
    logic [RATE_W-1:0]     rate_abs;
    logic [COUNT_W-1:0]    count_inc;
    logic                  pulse_fire;
    logic                  rate_neg;
    logic                  new_rate_pos;
    logic [stsp_pkg::MODE_W-1:0] mode_wr;

    stsp_pkg::cmd_req_t    cmd_req;
    stsp_pkg::cmd_result_t cmd_res;

    assign item.ready = !cmd_res.busy && (!result_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign is_tick    = accept && (item.data.operation == stsp_pkg::OP_TICK);
    assign is_speed   = accept && (item.data.operation == stsp_pkg::OP_SPEED);
    assign is_restart = accept && (item.data.operation == stsp_pkg::OP_RESTART);

    assign cmd_req.start     = is_speed;
    assign cmd_req.restart   = is_restart;
    assign cmd_req.speed     = item.data.speed_dps;
    assign cmd_req.limit_fwd = item.data.limit_fwd;
    assign cmd_req.limit_rev = item.data.limit_rev;

    stsp_sequencer #(
        .CONTROL_RATE_HZ (CONTROL_RATE_HZ),
        .TICK_RATE_HZ    (TICK_RATE_HZ),
        .RAMP_STEPS      (RAMP_STEPS),
        .MIN_PERIOD      (MIN_PERIOD)
    ) u_sequencer (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (cmd_req),
        .steps_per_rev (steps_per_rev_reg),
        .res           (cmd_res)
    );

    assign rate_neg     = pulse_rate_reg[RATE_W-1];
    assign rate_abs     = rate_neg ? (~pulse_rate_reg + 1'b1) : pulse_rate_reg;
    assign count_inc    = (tick_counter_reg == stsp_pkg::COUNT_MAX) ? tick_counter_reg
                                                                    : tick_counter_reg + 1'b1;
    assign pulse_fire   = (rate_abs[RATE_W-1:FRAC_W] != '0)
                       && (count_inc > {1'b0, tick_divider_reg});
    assign new_rate_pos = !cmd_res.rate[RATE_W-1] && (cmd_res.rate != '0);
    assign mode_wr      = wr_data[stsp_pkg::MODE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_per_rev_reg <= stsp_pkg::STEPS_PER_REV_RESET;
            pulse_mode_reg    <= stsp_pkg::MODE_STEP_DIR;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                stsp_pkg::REG_STEPS_PER_REV:
                begin
                    steps_per_rev_reg <= wr_data[stsp_pkg::PPR_W-1:0];
                end
                stsp_pkg::REG_PULSE_MODE:
                begin
                    // drop codes other than the two modes
                    if ((mode_wr == stsp_pkg::MODE_STEP_DIR)
                        || (mode_wr == stsp_pkg::MODE_PARITY))
                    begin
                        pulse_mode_reg <= mode_wr;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_rate_reg   <= '0;
            tick_divider_reg <= '0;
            tick_counter_reg <= '0;
            step_level_reg   <= 1'b0;
            line_state_reg   <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (is_tick)
            begin
                tick_counter_reg <= pulse_fire ? '0 : count_inc;
                if (pulse_fire)
                begin
                    priority if (pulse_mode_reg == stsp_pkg::MODE_STEP_DIR)
                    begin
                        step_level_reg    <= ~step_level_reg;
                        line_state_reg[0] <= ~step_level_reg;
                    end
                    else if (pulse_mode_reg == stsp_pkg::MODE_PARITY)
                    begin
                        line_state_reg <= rate_neg ? {1'b1, rate_abs[FRAC_W]}
                                                   : {rate_abs[FRAC_W], 1'b1};
                    end
                    else
                    begin
                        line_state_reg <= line_state_reg;
                    end
                end
            end

            if (is_restart)
            begin
                pulse_rate_reg <= '0;
            end

            if (cmd_res.done)
            begin
                pulse_rate_reg   <= cmd_res.rate;
                tick_divider_reg <= cmd_res.period;
                if (pulse_mode_reg == stsp_pkg::MODE_STEP_DIR)
                begin
                    line_state_reg[1] <= !new_rate_pos;
                end
            end

            if ((accept && !is_speed) || cmd_res.done)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result.valid             = result_valid_reg;
    assign result.data.line_a       = line_state_reg[0];
    assign result.data.line_b       = line_state_reg[1];
    assign result.data.rate_pulses  = pulse_rate_reg;
    assign result.data.period_ticks = tick_divider_reg;

endmodule

`default_nettype wire

/* src/stsp_checker.sv */
// ----------------------------------------------------------------------------
// Speed-to-step pulse generator checker
// Port-level checks on request and result timing, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "speed_to_step_pulse_generator_unit_macros.svh"

module stsp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          item_valid,
    input wire logic                          item_ready,
    input wire logic [stsp_pkg::OP_W-1:0]     item_op,
    input wire logic                          result_valid,
    input wire logic                          result_ready,
    input wire logic [stsp_pkg::RATE_W-1:0]   result_rate
);

    logic item_accept;
    logic result_stall;

    assign item_accept  = item_valid && item_ready;
    assign result_stall = result_valid && !result_ready;

    `STSP_ASSERT_NEXT(a_result_held, result_stall, result_valid, "result dropped while stalled")

    `STSP_ASSERT_NOW(a_no_accept_on_stall, result_stall, !item_ready, "request taken over a stalled result")

    `STSP_ASSERT_NEXT(a_short_op_result, item_accept && (item_op != stsp_pkg::OP_SPEED), result_valid, "no result after a one-cycle request")

    `STSP_ASSERT_NEXT(a_speed_busy, item_accept && (item_op == stsp_pkg::OP_SPEED), !item_ready && !result_valid, "speed command not held busy")

    `STSP_ASSERT_NEXT(a_restart_rate, item_accept && (item_op == stsp_pkg::OP_RESTART), result_rate == '0, "restart left a rate")

endmodule

bind speed_to_step_pulse_generator_unit stsp_checker u_stsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .item_op      (item.data.operation),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_rate  (result.data.rate_pulses)
);

`default_nettype wire
